### rtl/core/falt_pkg.sv
// Package for the failed-attempt lockout table.
// Holds op and config index codes, the sequencer state type, the table entry
// layout and reset defaults. No dependencies.
package falt_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int CFG_DATA_W  = 16;

  localparam logic [7:0]  ATTEMPT_LIMIT_RST   = 8'd5;
  localparam logic [15:0] LOCKOUT_SECONDS_RST = 16'd60;
  localparam logic [7:0]  ATTEMPTS_MAX        = 8'hFF;

  typedef enum logic [1:0] {
    OP_QUERY   = 2'd0,
    OP_FAILURE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  typedef enum logic {
    CFG_ATTEMPT_LIMIT   = 1'b0,
    CFG_LOCKOUT_SECONDS = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  attempts;
    logic [31:0] unlock_time;
  } entry_t;

endpackage

### rtl/core/failed_attempt_lockout_table_unit.sv
// Failed-attempt lockout table: per-key attempt counts and lock times.
// Ops 0-2: start, a key scan of the n entries in use (at most ENTRIES), an update, out_valid.
// Op 3 answers in the cycle after start. Throughput: one item at a time, busy while it works;
// the cost is a linear key scan through one single-port entry memory, one entry per cycle.
// Reset (rst_n low, synchronous) empties the table and loads the register defaults.
// Results are pulsed on out_valid for one cycle; the receiver cannot stall them.
module failed_attempt_lockout_table_unit
  import falt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_op,
  input  logic [31:0]           in_user_key,
  input  logic [31:0]           in_now,
  output logic                  out_valid,
  output logic                  out_limited,
  output logic                  out_found,
  output logic                  out_table_full,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(ENTRIES + 1);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  state_t state_r, state_nxt;

  logic [7:0]    limit_r;
  logic [15:0]   lockout_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [AW-1:0] pend_idx_r;
  logic          pend_r;
  logic [AW-1:0] hit_idx_r;
  logic          found_r;
  logic [1:0]    op_r;
  logic [31:0]   key_r;
  logic [31:0]   now_r;
  entry_t        rdata_r;

  logic          out_valid_r, out_limited_r, out_found_r, out_full_r;

  entry_t        entry_mem [ENTRIES];

  logic          issuing, hit, miss, rd_en;
  logic          wr_en, do_insert, room;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  logic          upd_limited, upd_full;
  logic [7:0]    att_inc;
  logic [32:0]   unlock_sum;
  logic [31:0]   unlock_sat;

  // ---------------- sequencer ----------------
  assign issuing = (idx_r < count_r);
  assign hit     = pend_r && (rdata_r.key == key_r);
  assign miss    = !issuing && !hit;
  assign room    = (count_r != CW'(ENTRIES));

  always_comb begin
    state_nxt = state_r;
    rd_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start && (in_op inside {OP_QUERY, OP_FAILURE, OP_CLEAR})) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || miss) begin
          state_nxt = ST_UPDATE;
        end else begin
          rd_en = issuing;
        end
      end
      ST_UPDATE: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- update datapath ----------------
  assign att_inc    = (rdata_r.attempts == ATTEMPTS_MAX) ? rdata_r.attempts
                                                         : rdata_r.attempts + 8'd1;
  assign unlock_sum = {1'b0, now_r} + {17'd0, lockout_r};
  assign unlock_sat = unlock_sum[32] ? 32'hFFFF_FFFF : unlock_sum[31:0];

  always_comb begin
    wr_data     = rdata_r;
    wr_addr     = hit_idx_r;
    wr_en       = 1'b0;
    do_insert   = 1'b0;
    upd_limited = 1'b0;
    upd_full    = 1'b0;
    if (state_r == ST_UPDATE) begin
      if (found_r) begin
        case (op_r)
          OP_QUERY: begin
            if (now_r < rdata_r.unlock_time) begin
              upd_limited = 1'b1;
            end else begin
              wr_en            = 1'b1;
              wr_data.attempts = 8'd0;
            end
          end
          OP_FAILURE: begin
            wr_en            = 1'b1;
            wr_data.attempts = att_inc;
            if (att_inc >= limit_r) begin
              wr_data.unlock_time = unlock_sat;
            end
          end
          OP_CLEAR: begin
            wr_en               = 1'b1;
            wr_data.attempts    = 8'd0;
            wr_data.unlock_time = 32'd0;
          end
          default: ;
        endcase
      end else if (op_r inside {OP_QUERY, OP_FAILURE}) begin
        if (room) begin
          do_insert           = 1'b1;
          wr_en               = 1'b1;
          wr_addr             = count_r[AW-1:0];
          wr_data.key         = key_r;
          wr_data.attempts    = (op_r == OP_FAILURE) ? 8'd1 : 8'd0;
          wr_data.unlock_time = 32'd0;
        end else begin
          upd_full = 1'b1;
        end
      end
    end
  end

  // ---------------- entry memory ----------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= entry_mem[idx_r[AW-1:0]];
    end
  end

  // ---------------- control and payload registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= ATTEMPT_LIMIT_RST;
      lockout_r   <= LOCKOUT_SECONDS_RST;
      count_r     <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ATTEMPT_LIMIT:   limit_r   <= cfg_data[7:0];
          CFG_LOCKOUT_SECONDS: lockout_r <= cfg_data;
          default: ;
        endcase
      end
      out_valid_r <= 1'b0;
      pend_r      <= rd_en;
      if (state_r == ST_IDLE && start) begin
        idx_r  <= '0;
        pend_r <= 1'b0;
        // op 3 answers with all-zero fields and touches nothing
        if (!(in_op inside {OP_QUERY, OP_FAILURE, OP_CLEAR})) begin
          out_valid_r <= 1'b1;
        end
      end
      if (rd_en) begin
        idx_r <= idx_r + CW'(1);
      end
      if (do_insert) begin
        count_r <= count_r + CW'(1);
      end
      if (state_r == ST_UPDATE) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && start) begin
      op_r          <= in_op;
      key_r         <= in_user_key;
      now_r         <= in_now;
      out_limited_r <= 1'b0;
      out_found_r   <= 1'b0;
      out_full_r    <= 1'b0;
    end
    if (rd_en) begin
      pend_idx_r <= idx_r[AW-1:0];
    end
    if (state_r == ST_SCAN) begin
      found_r   <= hit;
      hit_idx_r <= pend_idx_r;
    end
    if (state_r == ST_UPDATE) begin
      out_limited_r <= upd_limited;
      out_found_r   <= found_r;
      out_full_r    <= upd_full;
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_limited    = out_limited_r;
  assign out_found      = out_found_r;
  assign out_table_full = out_full_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(ENTRIES))
    else $error("fill count beyond table depth");

  a_update_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_UPDATE |=> out_valid_r)
    else $error("update did not produce a result");

  a_limited_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_limited_r |-> out_found_r)
    else $error("limited reported for an unknown key");

  a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> !out_found_r)
    else $error("table full reported for a known key");
`endif

endmodule
